FILE: sv/shfd_pkg.sv
// Package: item types, frame constants, parser phases and the CRC-16 byte update.
package shfd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // Index of the last parameter byte
    localparam logic [1:0]  PARAM_LAST  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_PARAM = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  command_code;
        logic [31:0] parameter_word;
        logic        frame_status;
        logic [15:0] computed_crc;
    } t_out_item;

    // One byte through the CRC, MSB first, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/shfd_in_if.sv
// Interface: input byte channel with valid/ready handshake.
interface shfd_in_if;
    logic                valid;
    logic                ready;
    shfd_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/shfd_out_if.sv
// Interface: frame result channel with valid/ready handshake.
interface shfd_out_if;
    logic                valid;
    logic                ready;
    shfd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/sync_header_frame_deframer_crc16_core.sv
// Top level: sync-header frame parser with CRC-16 check over sync, command and parameter.
//
//  Channel  Dir  Payload                                              Handshake
//  i_in     in   rx_byte[7:0]                                         valid/ready
//  o_out    out  command_code[7:0], parameter_word[31:0],             valid/ready
//                frame_status, computed_crc[15:0]
//
// Flow: one byte per cycle sustained, unless a frame's last byte waits on a full result
//   register; a byte is taken into the input register, then parsed and CRC-updated
//   from there, and the result register loads as the last byte of a frame is parsed.
// Reset: synchronous, active low; parser returns to hunting, CRC to 0xFFFF.
// Stalls: only the last byte of a frame waits on the output register; any other
//   byte is parsed even while a finished result is still held.
module sync_header_frame_deframer_crc16_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shfd_in_if.sink     i_in,
    shfd_out_if.source  o_out
);
    import shfd_pkg::*;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Parser state
    t_phase      r_phase,   n_phase;
    logic [1:0]  r_idx,     n_idx;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_cmd,     n_cmd;
    logic [31:0] r_param,   n_param;
    logic [7:0]  r_crc_lo,  n_crc_lo;

    // Result register
    logic        r_out_vld;
    t_out_item   r_out_data, n_out_data;
    logic        n_emit;

    logic        out_free;
    logic        process;
    logic [15:0] crc_next;
    logic [15:0] rx_crc;

    assign crc_next = crc_feed(r_crc, r_in_byte);
    assign rx_crc   = {r_in_byte, r_crc_lo};

    // The held byte may advance unless it completes a frame and the result slot is full
    assign out_free = !r_out_vld || o_out.ready;
    assign process  = r_in_vld && (out_free || (r_phase != PH_CRCHI));

    assign i_in.ready    = !r_in_vld || process;
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out_data;

    // Parse the held byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_cmd      = r_cmd;
        n_param    = r_param;
        n_crc_lo   = r_crc_lo;
        n_emit     = 1'b0;
        n_out_data = r_out_data;
        unique case (r_phase)
            PH_SYNC2: begin
                // A broken sync pair consumes this byte too
                if (r_in_byte == SYNC_SECOND) begin
                    n_crc   = crc_next;
                    n_phase = PH_CMD;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CMD: begin
                n_cmd   = r_in_byte;
                n_crc   = crc_next;
                n_param = '0;
                n_idx   = '0;
                n_phase = PH_PARAM;
            end
            PH_PARAM: begin
                // Little-endian: first parameter byte lands in bits 7..0
                n_param[r_idx*8 +: 8] = r_in_byte;
                n_crc                 = crc_next;
                if (r_idx == PARAM_LAST) begin
                    n_idx   = '0;
                    n_phase = PH_CRCLO;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            PH_CRCLO: begin
                n_crc_lo = r_in_byte;
                n_phase  = PH_CRCHI;
            end
            PH_CRCHI: begin
                n_emit                    = 1'b1;
                n_out_data.command_code   = r_cmd;
                n_out_data.parameter_word = r_param;
                n_out_data.frame_status   = (rx_crc != r_crc);
                n_out_data.computed_crc   = r_crc;
                n_phase                   = PH_HUNT;
                n_idx                     = '0;
                n_crc                     = CRC_INIT;
            end
            default: begin
                // Hunting: ignore everything but the first sync byte
                n_phase = PH_HUNT;
                if (r_in_byte == SYNC_FIRST) begin
                    n_crc   = crc_feed(CRC_INIT, r_in_byte);
                    n_phase = PH_SYNC2;
                end
            end
        endcase
    end

    // Input register: hold a byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.payload.rx_byte;
        end
    end

    // Parser state: advance on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_crc   <= CRC_INIT;
        end else if (process) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
        end
        if (process) begin
            r_cmd    <= n_cmd;
            r_param  <= n_param;
            r_crc_lo <= n_crc_lo;
        end
    end

    // Result register: load on a completed frame, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (process && n_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (process && n_emit) begin
            r_out_data <= n_out_data;
        end
    end

    // A held byte that is not processed stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !process |=> r_in_vld && $stable(r_in_byte))
        else $error("input register lost or changed a waiting byte");

    // A completed frame always yields a result and a return to hunting
    a_frame_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && (r_phase == PH_CRCHI) |=> r_out_vld && (r_phase == PH_HUNT))
        else $error("completed frame did not produce a result");

    // Results only come from the last CRC byte
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(process && (r_phase == PH_CRCHI)))
        else $error("result produced outside the last CRC byte");

    // An untaken result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_out_data))
        else $error("pending result overwritten");

    // The parameter byte counter rests at zero outside the parameter phase
    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_PARAM) |-> (r_idx == '0))
        else $error("byte counter not at zero outside parameter phase");

endmodule

FILE: tb/shfd_tb_pkg.sv
// Scoreboard class for the frame parser: byte-level prediction and result checking.
`timescale 1ns / 1ps

package shfd_tb_pkg;

    import shfd_pkg::*;

    class frame_result_tracker;

        t_phase      phase;
        logic [2:0]  param_idx;
        logic [15:0] crc_run;
        logic [7:0]  cmd_held;
        logic [31:0] param_held;
        logic [7:0]  crc_lo_held;
        t_out_item   frames_due[$];
        int          errors;

        function new();
            phase       = PH_HUNT;
            param_idx   = '0;
            crc_run     = CRC_INIT;
            cmd_held    = '0;
            param_held  = '0;
            crc_lo_held = '0;
            errors      = 0;
        endfunction

        // Bit-serial CRC-16, MSB first
        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ b[k];
                c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        // Advance the parser by one accepted byte; queue a result on the last CRC byte
        function void take_byte(logic [7:0] b);
            t_out_item frame;
            case (phase)
                PH_SYNC2: begin
                    if (b == SYNC_SECOND) begin
                        crc_run = crc_step(crc_run, b);
                        phase   = PH_CMD;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_CMD: begin
                    cmd_held   = b;
                    crc_run    = crc_step(crc_run, b);
                    param_held = '0;
                    param_idx  = '0;
                    phase      = PH_PARAM;
                end
                PH_PARAM: begin
                    param_held[8*param_idx[1:0] +: 8] = b;
                    crc_run = crc_step(crc_run, b);
                    if (param_idx[1:0] == PARAM_LAST) begin
                        param_idx = '0;
                        phase     = PH_CRCLO;
                    end else begin
                        param_idx = param_idx + 3'd1;
                    end
                end
                PH_CRCLO: begin
                    crc_lo_held = b;
                    phase       = PH_CRCHI;
                end
                PH_CRCHI: begin
                    frame.command_code   = cmd_held;
                    frame.parameter_word = param_held;
                    frame.frame_status   = ({b, crc_lo_held} == crc_run) ? 1'b0 : 1'b1;
                    frame.computed_crc   = crc_run;
                    frames_due.push_back(frame);
                    phase     = PH_HUNT;
                    param_idx = '0;
                    crc_run   = CRC_INIT;
                end
                default: begin
                    phase = PH_HUNT;
                    if (b == SYNC_FIRST) begin
                        crc_run = crc_step(CRC_INIT, b);
                        phase   = PH_SYNC2;
                    end
                end
            endcase
        endfunction

        function void check_frame(t_out_item got);
            t_out_item want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame result %h", $time, got);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.command_code !== want.command_code) begin
                $display("%0t: command_code expected %h actual %h",
                         $time, want.command_code, got.command_code);
                errors++;
            end
            if (got.parameter_word !== want.parameter_word) begin
                $display("%0t: parameter_word expected %h actual %h",
                         $time, want.parameter_word, got.parameter_word);
                errors++;
            end
            if (got.frame_status !== want.frame_status) begin
                $display("%0t: frame_status expected %b actual %b",
                         $time, want.frame_status, got.frame_status);
                errors++;
            end
            if (got.computed_crc !== want.computed_crc) begin
                $display("%0t: computed_crc expected %h actual %h",
                         $time, want.computed_crc, got.computed_crc);
                errors++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_sync_header_frame_deframer_crc16_core.sv
// Testbench top: drives framed and noisy byte streams into the parser and checks every result.
`timescale 1ns / 1ps

module tb_sync_header_frame_deframer_crc16_core;

    import shfd_pkg::*;
    import shfd_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 350;

    logic i_clk;
    logic i_rst_n;

    shfd_in_if  in_ch ();
    shfd_out_if out_ch ();

    sync_header_frame_deframer_crc16_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    frame_result_tracker tracker;

    // Percentages of cycles in which each side holds off
    int tx_idle_pct;
    int rx_idle_pct;
    int bytes_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: decide ready at each falling edge
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: sample accepted results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_frame(out_ch.payload);
        end
    end

    // Offer one byte, idling first at random, and hold it until it is taken.
    // Valid gets a single assignment per falling edge, so back-to-back items keep it high.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.payload.rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!(in_ch.valid && in_ch.ready));
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // Send a whole frame; a non-zero crc_flip corrupts the transmitted CRC
    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] param,
                              input logic [15:0] crc_flip);
        logic [15:0] crc;
        logic [7:0]  body [7];
        body[0] = SYNC_FIRST;
        body[1] = SYNC_SECOND;
        body[2] = cmd;
        body[3] = param[7:0];
        body[4] = param[15:8];
        body[5] = param[23:16];
        body[6] = param[31:24];
        crc = CRC_INIT;
        foreach (body[i]) begin
            crc = frame_result_tracker::crc_step(crc, body[i]);
            send_byte(body[i]);
        end
        crc = crc ^ crc_flip;
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    // Hold the sender until every queued result has come out
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One random burst: mostly clean frames, some corrupted, some broken sync and noise
    task automatic send_random_burst();
        int          pick;
        int          n;
        logic [7:0]  cmd;
        logic [31:0] param;
        logic [15:0] flip;
        logic [7:0]  b;
        pick  = $urandom_range(99);
        cmd   = 8'($urandom_range(255));
        param = $urandom;
        case ($urandom_range(7))
            0: param = 32'h0000_0000;
            1: param = 32'hFFFF_FFFF;
            default: ;
        endcase
        if (pick < 75) begin
            send_frame(cmd, param, 16'h0000);
        end else if (pick < 88) begin
            flip = 16'($urandom_range(65535));
            if (flip == 16'h0000) flip = 16'h0001;
            send_frame(cmd, param, flip);
        end else if (pick < 94) begin
            // Broken sync pair: the second byte is anything but 0x55
            b = 8'($urandom_range(255));
            if (b == SYNC_SECOND) b = SYNC_FIRST;
            send_byte(SYNC_FIRST);
            send_byte(b);
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        tracker              = new();
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.payload        = '0;
        out_ch.ready         = 1'b0;
        tx_idle_pct          = 0;
        rx_idle_pct          = 0;
        bytes_sent           = 0;

        // Hold reset, release on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: stray bytes while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        // All-zero frame with a good CRC
        send_frame(8'h00, 32'h0000_0000, 16'h0000);
        // All-ones frame with a bad CRC: still reported, flagged in frame_status
        send_frame(8'hFF, 32'hFFFF_FFFF, 16'h8000);
        // Broken sync where the second byte is itself 0xAA, then a lone 0x55
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // Broken sync with an ordinary byte
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // Mixed-bit frame with a good CRC
        send_frame(8'h80, 32'h8000_0001, 16'h0000);

        // Random phases: receiver idles heavily, then sender, then neither
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 68;
                end
                1: begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            while (bytes_sent < (ph + 1) * ITEMS_PER_PHASE) begin
                send_random_burst();
            end
            // Pause the sender until the result queue is empty
            drain_results();
        end

        // Let any late or stray result show up before deciding
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
